FILE: rtl/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

    // Deepest pattern the window can hold.
    localparam int MAX_PATTERN = 16;
    // The pattern registers carry sixteen byte positions.
    localparam int PATTERN_REG_BYTES = 16;
    localparam int PAT_CAP = (MAX_PATTERN < PATTERN_REG_BYTES) ? MAX_PATTERN
                                                               : PATTERN_REG_BYTES;

    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 48;
    localparam int CFG_W    = 64;
    localparam int CARE_W   = 16;
    localparam int PLEN_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Fill count width: holds MAX_PATTERN and never narrower than a pattern length.
    localparam int FILL_BITS = $clog2(MAX_PATTERN + 1);
    localparam int LEN_W     = (FILL_BITS > PLEN_W) ? FILL_BITS : PLEN_W;
    localparam int WIN_IDX_W = ($clog2(MAX_PATTERN) > 0) ? $clog2(MAX_PATTERN) : 1;

    localparam int S_TDATA_W = ((BYTE_W + ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ADDR_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO = 2'd0,
        CFG_PAT_HI = 2'd1,
        CFG_CARE   = 2'd2,
        CFG_LEN    = 2'd3
    } t_cfg_idx;

    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0]       t_window;
    typedef logic [PATTERN_REG_BYTES-1:0][BYTE_W-1:0] t_pattern;

    // Configuration as seen by the datapath; len is already clamped to 1..PAT_CAP.
    typedef struct packed {
        t_pattern            pattern;
        logic [CARE_W-1:0]   care;
        logic [PLEN_W-1:0]   len;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/wildcard_byte_pattern_scan_core.sv
// Wildcard byte signature scanner. Bytes arrive one per transfer on the slave stream, with
// their address and a region-start flag in tuser; the block reports the address of the first
// byte of every occurrence of the programmed signature (overlapping ones included) on the master
// stream. A signature has 1 to 16 positions, each either an exact byte or a wildcard, and a
// match never spans a region start. The input register feeds a combinational parallel compare
// of every window position whose result goes to the output register; it sustains one byte per
// clock, but a stalled master side holds the whole pipeline. Program the pattern, care mask and
// length only while the stream is idle; the configuration channel always accepts.
`default_nettype none

module wildcard_byte_pattern_scan_core
    import wbps_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    // Byte stream in.
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // tdata, lowest bit first: data_byte [7:0], byte_addr [55:8].
    input  wire logic [S_TDATA_W-1:0]    i_s_axis_tdata,
    // tuser: region_start.
    input  wire logic                    i_s_axis_tuser,

    // Match reports out.
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    // tdata: match_addr [47:0].
    output logic [M_TDATA_W-1:0]         o_m_axis_tdata,

    // Register writes.
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data
);

    t_cfg                cfg;
    t_window             window;
    logic [LEN_W-1:0]    fill;
    logic                advance;
    logic                s_xfer;
    logic                hit;
    logic [ADDR_W-1:0]   match_addr;

    // Stage 1 holds the address of the byte that has just entered the window.
    logic                r_s1_valid;
    logic [ADDR_W-1:0]   r_s1_addr;

    // Output register.
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;

    // The pipeline moves whenever the output register is empty or being drained.
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = advance;
    assign s_xfer          = i_s_axis_tvalid && advance;
    assign o_cfg_ready     = 1'b1;

    wbps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The window register doubles as the input register of the compare stage.
    wbps_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (s_xfer),
        .i_byte   (i_s_axis_tdata[BYTE_W-1:0]),
        .i_start  (i_s_axis_tuser),
        .o_window (window),
        .o_fill   (fill)
    );

    wbps_match u_match (
        .i_cfg        (cfg),
        .i_window     (window),
        .i_fill       (fill),
        .i_addr       (r_s1_addr),
        .o_hit        (hit),
        .o_match_addr (match_addr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_s_axis_tvalid;
            r_out_valid <= r_s1_valid && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_s1_addr <= i_s_axis_tdata[BYTE_W +: ADDR_W];
        end
        if (advance) begin
            r_out_addr <= match_addr;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_out_addr);

endmodule

`default_nettype wire

FILE: rtl/wbps_cfg.sv
`default_nettype none

module wbps_cfg
    import wbps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire logic [CFG_IDX_W-1:0] i_index,
    input  wire logic [CFG_W-1:0]     i_data,
    output t_cfg                      o_cfg
);

    logic [CFG_W-1:0]  r_pat_lo;
    logic [CFG_W-1:0]  r_pat_hi;
    logic [CARE_W-1:0] r_care;
    logic [PLEN_W-1:0] r_len;
    logic [PLEN_W-1:0] n_len;
    logic [PLEN_W-1:0] len_raw;

    // The length is clamped when written, so the datapath never sees zero or an oversize value.
    always_comb begin
        len_raw = i_data[PLEN_W-1:0];
        if (len_raw == '0) begin
            n_len = PLEN_W'(1);
        end else if (len_raw > PLEN_W'(PAT_CAP)) begin
            n_len = PLEN_W'(PAT_CAP);
        end else begin
            n_len = len_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '0;
            r_len    <= PLEN_W'(1);
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_PAT_LO: r_pat_lo <= i_data;
                CFG_PAT_HI: r_pat_hi <= i_data;
                CFG_CARE:   r_care   <= i_data[CARE_W-1:0];
                CFG_LEN:    r_len    <= n_len;
            endcase
        end
    end

    assign o_cfg.pattern = t_pattern'({r_pat_hi, r_pat_lo});
    assign o_cfg.care    = r_care;
    assign o_cfg.len     = r_len;

endmodule

`default_nettype wire

FILE: rtl/wbps_window.sv
`default_nettype none

module wbps_window
    import wbps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_shift,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_start,
    output t_window                o_window,
    output logic [LEN_W-1:0]       o_fill
);

    t_window           r_window;
    logic [LEN_W-1:0]  r_fill;
    logic [LEN_W-1:0]  fill_base;
    logic [LEN_W-1:0]  n_fill;

    // A region start drops the count before the new byte is counted.
    always_comb begin
        fill_base = i_start ? '0 : r_fill;
        n_fill    = fill_base;
        if (fill_base < LEN_W'(MAX_PATTERN)) begin
            n_fill = fill_base + LEN_W'(1);
        end
    end

    // Entry 0 is the newest byte. Stale entries are masked by the fill count.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_window[0] <= i_byte;
            for (int k = 1; k < MAX_PATTERN; k++) begin
                r_window[k] <= r_window[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_shift) begin
            r_fill <= n_fill;
        end
    end

    assign o_window = r_window;
    assign o_fill   = r_fill;

endmodule

`default_nettype wire

FILE: rtl/wbps_match.sv
`default_nettype none

module wbps_match
    import wbps_pkg::*;
(
    input  wire t_cfg              i_cfg,
    input  wire t_window           i_window,
    input  wire logic [LEN_W-1:0]  i_fill,
    input  wire logic [ADDR_W-1:0] i_addr,
    output logic                   o_hit,
    output logic [ADDR_W-1:0]      o_match_addr
);

    logic [LEN_W-1:0]   len_ext;
    logic [PAT_CAP-1:0] pos_ok;
    logic [LEN_W-1:0]   win_pos [PAT_CAP];

    assign len_ext = LEN_W'(i_cfg.len);

    // Pattern position j lines up with window entry len - 1 - j.
    always_comb begin
        for (int j = 0; j < PAT_CAP; j++) begin
            win_pos[j] = len_ext - LEN_W'(1) - LEN_W'(j);
            pos_ok[j]  = 1'b1;
            if ((LEN_W'(j) < len_ext) && i_cfg.care[j]) begin
                pos_ok[j] = (i_window[win_pos[j][WIN_IDX_W-1:0]] == i_cfg.pattern[j]);
            end
        end
    end

    assign o_hit        = (i_fill >= len_ext) && (&pos_ok);
    assign o_match_addr = i_addr - ADDR_W'(i_cfg.len - PLEN_W'(1));

endmodule

`default_nettype wire

FILE: tb/wildcard_byte_pattern_scan_core_tb.sv
`default_nettype none

// Self-checking bench for the wildcard byte signature scanner.
//
// The initial block programs the registers while the stream is idle and loads the queue of
// pending bytes. A clocked driver offers them on the slave stream, and a clocked monitor
// takes match reports off the master stream. Whenever a byte transfer completes, the driver
// runs it through a behavioural copy of the scanner. That copy keeps its own window, fill
// count and register set. Each match it finds joins a queue of expected match addresses.
// The monitor compares every reported address with the oldest entry of that queue.
module wildcard_byte_pattern_scan_core_tb;
    import wbps_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    // Allow a good margin after the last result before touching registers.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_BYTES   = 96;

    // Pattern lengths written per phase: 0 must act as 1, and 31 or 20 must act as 16.
    localparam int LEN_TAB [NUM_PHASES] = '{1, 16, 5, 0, 31, 3, 8, 12, 2, 20, 4, 7};

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [ADDR_W-1:0] addr;
        logic              start;
    } t_scan_byte;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic                 i_s_axis_tuser = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Scanner state as the checker sees it. The window holds the newest byte in entry 0.
    logic [BYTE_W-1:0]    win [MAX_PATTERN] = '{default: '0};
    int unsigned          fill = 0;
    logic [CFG_W-1:0]     pat_lo = '0;
    logic [CFG_W-1:0]     pat_hi = '0;
    logic [CARE_W-1:0]    care = '0;
    logic [PLEN_W-1:0]    plen = PLEN_W'(1);

    t_scan_byte           byte_q [$];
    logic [ADDR_W-1:0]    match_q [$];
    t_scan_byte           offered;
    int unsigned          bytes_queued = 0;
    int unsigned          bytes_accepted = 0;
    int unsigned          errors = 0;
    int unsigned          cycles = 0;
    int unsigned          in_idle_pct = 0;
    int unsigned          out_idle_pct = 0;
    int unsigned          in_gap = 0;
    int unsigned          out_stall = 0;
    int unsigned          hold_left = 0;
    logic                 hold_armed = 1'b0;
    logic                 hold_done = 1'b0;
    logic                 ready_next;

    wildcard_byte_pattern_scan_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Length in use: zero counts as one, and anything past the register capacity is capped.
    function automatic int unsigned active_len();
        int unsigned l;
        l = plen;
        if (l == 0) l = 1;
        if (l > PAT_CAP) l = PAT_CAP;
        return l;
    endfunction

    function automatic logic [BYTE_W-1:0] pat_byte(int unsigned pos);
        if (pos < 8) return pat_lo[8*pos +: 8];
        return pat_hi[8*(pos-8) +: 8];
    endfunction

    // Takes one transferred byte into the window and queues the match address it produces.
    function automatic void scan_byte(t_scan_byte b);
        int unsigned l;
        logic hit;
        l = active_len();
        hit = 1'b1;
        // A region start empties the window before the byte goes in.
        if (b.start) fill = 0;
        for (int i = MAX_PATTERN - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = b.data;
        if (fill < MAX_PATTERN) fill++;
        if (fill < l) return;
        // Pattern position j lines up with the byte that arrived l-1-j transfers ago.
        for (int j = 0; j < l; j++)
            if (care[j] && win[l-1-j] != pat_byte(j)) hit = 1'b0;
        if (hit) match_q.insert(match_q.size(), b.addr - ADDR_W'(l - 1));
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    task automatic queue_byte(logic [BYTE_W-1:0] data, logic [ADDR_W-1:0] addr, logic start);
        t_scan_byte b;
        b.data = data;
        b.addr = addr;
        b.start = start;
        byte_q.insert(byte_q.size(), b);
        bytes_queued++;
    endtask

    // One register write; the checker's copy changes at the transfer.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PAT_LO: pat_lo = val;
            CFG_PAT_HI: pat_hi = val;
            CFG_CARE:   care = val[CARE_W-1:0];
            CFG_LEN:    plen = val[PLEN_W-1:0];
            default:    ;
        endcase
    endtask

    // Every queued byte has gone in and every expected match has come out. A trailing byte
    // that matches nothing may still be inside the block, hence the extra settling cycles.
    task automatic wait_idle();
        do @(posedge i_clk); while (bytes_accepted != bytes_queued || match_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_base();
        case ($urandom_range(0, 5))
            0:       return 48'hFFFF_FFFF_FFFF - ADDR_W'($urandom_range(0, 40));
            1:       return ADDR_W'($urandom_range(0, 20));
            default: return ADDR_W'({$urandom, $urandom});
        endcase
    endfunction

    // Mostly well-formed regions with consecutive addresses, some shorter than the pattern,
    // with occurrences of the signature planted in them. About one region in ten is noise:
    // scattered addresses and random region starts. Now and then a region also lacks its start.
    task automatic queue_traffic(int unsigned n);
        int unsigned left, rlen, l, pos, reps;
        logic [ADDR_W-1:0] base;
        logic [BYTE_W-1:0] region [];
        logic noisy;
        left = n;
        l = active_len();
        while (left > 0) begin
            noisy = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 3) == 0) rlen = $urandom_range(1, l);
            else rlen = $urandom_range(l, l + 40);
            if (rlen > left) rlen = left;
            region = new[rlen];
            // Half the filler bytes are taken from the pattern itself to provoke near misses.
            foreach (region[i])
                region[i] = $urandom_range(0, 1) ? pat_byte($urandom_range(0, l - 1))
                                                 : BYTE_W'($urandom);
            reps = $urandom_range(0, 3);
            repeat (reps) begin
                pos = $urandom_range(0, rlen - 1);
                for (int j = 0; j < l && pos + j < rlen; j++)
                    if (care[j]) region[pos+j] = pat_byte(j);
            end
            base = pick_base();
            foreach (region[i]) begin
                if (noisy)
                    queue_byte(region[i], ADDR_W'({$urandom, $urandom}),
                               1'($urandom_range(0, 1)));
                else
                    queue_byte(region[i], base + ADDR_W'(i), i == 0 && $urandom_range(0, 19) != 0);
            end
            left -= rlen;
        end
    endtask

    // Byte stream driver. A transfer at this edge is handed to the checker's copy, then the
    // next byte, or an idle burst, is set up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                scan_byte(offered);
                bytes_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (in_gap != 0) begin
                    in_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (byte_q.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
                    in_gap = $urandom_range(0, 4);
                    i_s_axis_tvalid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    offered = byte_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= S_TDATA_W'({offered.addr, offered.data});
                    i_s_axis_tuser <= offered.start;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off of the master side, so that the block fills up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Match report monitor and the random ready pattern of the master side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (match_q.size() == 0)
                    report_mismatch($sformatf("unexpected match at %h",
                                              o_m_axis_tdata[ADDR_W-1:0]));
                else if (o_m_axis_tdata[ADDR_W-1:0] != match_q[0])
                    report_mismatch($sformatf("match_addr %h, expected %h",
                                              o_m_axis_tdata[ADDR_W-1:0], match_q.pop_front()));
                else
                    void'(match_q.pop_front());
            end
            if (out_stall != 0) begin
                out_stall--;
                ready_next = 1'b0;
            end else if ($urandom_range(0, 99) < out_idle_pct) begin
                out_stall = $urandom_range(0, 4);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            i_m_axis_tready <= ready_next && hold_left == 0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [CARE_W-1:0] care_val;
        logic [CFG_W-1:0]  lo_val, hi_val;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. With the register values at reset every byte matches by itself.
        in_idle_pct = 20;
        out_idle_pct = 20;
        queue_byte(8'h00, 48'h0000_0000_0000, 1'b1);
        queue_byte(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_byte(8'hA5, 48'h5A5A_A5A5_0F0F, 1'b1);
        queue_byte(8'h5A, 48'hA5A5_5A5A_F0F1, 1'b0);
        wait_idle();

        // A length of zero behaves as one; ignored upper bits of the care write are all set.
        write_reg(CFG_PAT_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_CARE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_LEN, 64'h0);
        queue_byte(8'hFF, 48'h0000_0000_0100, 1'b1);
        queue_byte(8'h00, 48'h0000_0000_0101, 1'b0);
        queue_byte(8'hFE, 48'h0000_0000_0102, 1'b0);
        wait_idle();

        // An oversized length caps at sixteen. All positions are wildcards, so the sixteenth
        // and seventeenth bytes give overlapping matches, with addresses wrapping past the top.
        write_reg(CFG_CARE, 64'h0);
        write_reg(CFG_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 17; i++)
            queue_byte(BYTE_W'($urandom), 48'hFFFF_FFFF_FFF8 + ADDR_W'(i), i == 0);
        wait_idle();

        // Random part, one register setting per phase. Every third phase, and the last two as well,
        // run without idling on either side.
        for (int k = 0; k < NUM_PHASES; k++) begin
            lo_val = (k == 4) ? '1 : (k == 6) ? '0 : CFG_W'({$urandom, $urandom});
            hi_val = (k == 4) ? '1 : (k == 7) ? '0 : CFG_W'({$urandom, $urandom});
            if (k == 2) care_val = '0;
            else if (k % 4 == 0) care_val = '1;
            else if (k % 4 == 3) care_val = CARE_W'($urandom & $urandom);
            else care_val = CARE_W'($urandom);
            write_reg(CFG_PAT_LO, lo_val);
            write_reg(CFG_PAT_HI, hi_val);
            write_reg(CFG_CARE, CFG_W'({CFG_W'({$urandom, $urandom}) >> CARE_W, care_val}));
            write_reg(CFG_LEN,
                      CFG_W'({CFG_W'({$urandom, $urandom}) >> PLEN_W, PLEN_W'(LEN_TAB[k])}));
            if (k % 3 == 0 || k >= NUM_PHASES - 2) begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct = 25;
                out_idle_pct = 30;
            end
            queue_traffic(PHASE_BYTES);
            // All-wildcard phase: nearly every byte matches, which suits the long hold-off.
            if (k == 2) hold_armed = 1'b1;
            wait_idle();
        end

        if (errors == 0 && match_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
